FILE: hdl/bbe_pkg.sv
// Shared types and constants of the bisquare basis evaluator.
package bbe_pkg;

    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_BITS = WEIGHT_FRAC + 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int COUNT_BITS = 7;
    localparam int ROW_BITS = 24;
    localparam int SLOT_BITS = 6;
    localparam int COL_BITS = 6;
    localparam int MUL_BITS = 33;
    localparam int OP_BITS = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_RSQ  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_REC  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_RSQ   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_REC   = 3'd5;

    // Datapath operations issued by the controller.
    localparam logic [OP_BITS-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_BITS-1:0] OP_ACCEPT = 5'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 5'd2;
    localparam logic [OP_BITS-1:0] OP_DIFF   = 5'd3;
    localparam logic [OP_BITS-1:0] OP_SQX    = 5'd4;
    localparam logic [OP_BITS-1:0] OP_SQY    = 5'd5;
    localparam logic [OP_BITS-1:0] OP_SQT    = 5'd6;
    localparam logic [OP_BITS-1:0] OP_D2     = 5'd7;
    localparam logic [OP_BITS-1:0] OP_R0     = 5'd8;
    localparam logic [OP_BITS-1:0] OP_R1     = 5'd9;
    localparam logic [OP_BITS-1:0] OP_R2     = 5'd10;
    localparam logic [OP_BITS-1:0] OP_R3     = 5'd11;
    localparam logic [OP_BITS-1:0] OP_R4     = 5'd12;
    localparam logic [OP_BITS-1:0] OP_R5     = 5'd13;
    localparam logic [OP_BITS-1:0] OP_WS     = 5'd14;
    localparam logic [OP_BITS-1:0] OP_WF     = 5'd15;
    localparam logic [OP_BITS-1:0] OP_EMIT   = 5'd16;
    localparam logic [OP_BITS-1:0] OP_FIN    = 5'd17;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               rsel;
    } dp_cmd_t;

    typedef struct packed {
        logic                  mode;
        logic [COUNT_BITS-1:0] count;
        logic                  hit_ok;
        logic                  pend_valid;
        logic                  out_free;
    } dp_status_t;

endpackage

FILE: hdl/bbe_ctrl.sv
// Sequencer that walks the center table and drives the datapath one step a cycle while the output does not stall it.
module bbe_ctrl #(
    parameter int CENTERS = 64,
    parameter int IW = 6,
    parameter int JW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                req_type,
    output logic                in_ready,
    input  bbe_pkg::dp_status_t status,
    output bbe_pkg::dp_cmd_t    cmd,
    output logic [IW-1:0]       idx
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_DIF  = 5'd2;
    localparam logic [4:0] S_SQX  = 5'd3;
    localparam logic [4:0] S_SQY  = 5'd4;
    localparam logic [4:0] S_SQT  = 5'd5;
    localparam logic [4:0] S_D2   = 5'd6;
    localparam logic [4:0] S_CMP  = 5'd7;
    localparam logic [4:0] S_R0   = 5'd8;
    localparam logic [4:0] S_R1   = 5'd9;
    localparam logic [4:0] S_R2   = 5'd10;
    localparam logic [4:0] S_R3   = 5'd11;
    localparam logic [4:0] S_R4   = 5'd12;
    localparam logic [4:0] S_R5   = 5'd13;
    localparam logic [4:0] S_WS   = 5'd14;
    localparam logic [4:0] S_WF   = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;

    logic [4:0]    state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;
    logic          rsel_reg, rsel_next;
    logic [JW-1:0] n_lim;
    logic [JW-1:0] j_inc;
    logic          at_end;

    always_comb
    begin
        if (32'(status.count) > CENTERS)
            n_lim = JW'(CENTERS);
        else
            n_lim = JW'(status.count);
    end

    assign j_inc  = JW'(j_reg + 1'b1);
    assign at_end = (j_inc == n_lim);
    assign idx    = j_reg[IW-1:0];
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        rsel_next  = rsel_reg;
        cmd.op     = bbe_pkg::OP_NOP;
        cmd.rsel   = rsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = bbe_pkg::OP_ACCEPT;
                    j_next = '0;
                    if (req_type)
                        state_next = (n_lim == '0) ? S_FIN : S_RD;
                end
            end
            S_RD:  begin cmd.op = bbe_pkg::OP_READ; state_next = S_DIF; end
            S_DIF: begin cmd.op = bbe_pkg::OP_DIFF; state_next = S_SQX; end
            S_SQX: begin cmd.op = bbe_pkg::OP_SQX;  state_next = S_SQY; end
            S_SQY: begin cmd.op = bbe_pkg::OP_SQY;  state_next = S_SQT; end
            S_SQT: begin cmd.op = bbe_pkg::OP_SQT;  state_next = S_D2;  end
            S_D2:  begin cmd.op = bbe_pkg::OP_D2;   state_next = S_CMP; end
            S_CMP:
            begin
                if (status.hit_ok)
                begin
                    rsel_next  = 1'b0;
                    state_next = S_R0;
                end
                else if (at_end)
                    state_next = S_FIN;
                else
                begin
                    j_next     = j_inc;
                    state_next = S_RD;
                end
            end
            S_R0: begin cmd.op = bbe_pkg::OP_R0; state_next = S_R1; end
            S_R1: begin cmd.op = bbe_pkg::OP_R1; state_next = S_R2; end
            S_R2: begin cmd.op = bbe_pkg::OP_R2; state_next = S_R3; end
            S_R3: begin cmd.op = bbe_pkg::OP_R3; state_next = S_R4; end
            S_R4: begin cmd.op = bbe_pkg::OP_R4; state_next = S_R5; end
            S_R5:
            begin
                cmd.op = bbe_pkg::OP_R5;
                if (!rsel_reg && status.mode)
                begin
                    rsel_next  = 1'b1;
                    state_next = S_R0;
                end
                else
                    state_next = S_WS;
            end
            S_WS: begin cmd.op = bbe_pkg::OP_WS; state_next = S_WF; end
            S_WF: begin cmd.op = bbe_pkg::OP_WF; state_next = S_EMIT; end
            S_EMIT:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.op = bbe_pkg::OP_EMIT;
                    if (at_end)
                        state_next = S_FIN;
                    else
                    begin
                        j_next     = j_inc;
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = bbe_pkg::OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            rsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            rsel_reg  <= rsel_next;
        end
    end

endmodule

FILE: hdl/bbe_datapath.sv
// Center table, configuration registers, shared multiplier and output staging.
module bbe_datapath #(
    parameter int CENTERS = 64,
    parameter int COORD_BITS = 24,
    parameter int IW = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bbe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                req_type,
    input  logic [bbe_pkg::SLOT_BITS-1:0]       center_slot,
    input  logic [bbe_pkg::ROW_BITS-1:0]        point_row,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    input  logic signed [COORD_BITS-1:0]        coord_t,
    input  bbe_pkg::dp_cmd_t                    cmd,
    input  logic [IW-1:0]                       idx,
    output bbe_pkg::dp_status_t                 status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bbe_pkg::ROW_BITS-1:0]        row_index,
    output logic [bbe_pkg::COL_BITS-1:0]        center_col,
    output logic [bbe_pkg::WEIGHT_BITS-1:0]     weight,
    output logic                                hit,
    output logic                                last
);

    localparam int CB = COORD_BITS;
    localparam int MB = bbe_pkg::MUL_BITS;
    localparam int WB = bbe_pkg::WEIGHT_BITS;
    localparam int WF = bbe_pkg::WEIGHT_FRAC;
    localparam logic [WB-1:0] ONE_W = WB'(1) << WF;

    typedef logic [3*CB-1:0] entry_t;

    entry_t                mem [CENTERS];
    entry_t                cen_reg;

    logic                  mode_reg;
    logic [6:0]            count_reg;
    logic [48:0]           srsq_reg, trsq_reg;
    logic [63:0]           srec_reg, trec_reg;

    logic signed [CB-1:0]  px_reg, py_reg, pt_reg;
    logic [bbe_pkg::ROW_BITS-1:0] row_reg;
    logic [CB:0]           mx_reg, my_reg, mt_reg;
    logic [2*MB-1:0]       prod_reg;
    logic [63:0]           sqx_reg, sqy_reg, sqt_reg, d2_reg;
    logic [127:0]          acc_reg;
    logic [WB-1:0]         ra_reg, rb_reg, w_reg;

    logic                  pend_valid_reg;
    logic [bbe_pkg::COL_BITS-1:0] pend_col_reg;
    logic [WB-1:0]         pend_w_reg;

    logic                  out_valid_reg;
    logic [bbe_pkg::ROW_BITS-1:0] out_row_reg;
    logic [bbe_pkg::COL_BITS-1:0] out_col_reg;
    logic [WB-1:0]         out_w_reg;
    logic                  out_hit_reg, out_last_reg;

    logic                  out_free;
    logic [MB-1:0]         mul_a, mul_b;
    logic [63:0]           prod_sat;
    logic [64:0]           d2_sum;
    logic [63:0]           rin, rrec;
    logic [WB-1:0]         ratio_val;
    logic [63:0]           ratio_q;
    logic [WB:0]           s_val;
    logic signed [CB:0]    dx, dy, dt;
    logic                  push;

    // Signed coordinate differences and their magnitudes.
    function automatic logic [CB:0] mag(input logic signed [CB:0] d);
        mag = d[CB] ? (~d + 1'b1) : d;
    endfunction

    assign dx = {px_reg[CB-1], px_reg} - {cen_reg[3*CB-1], cen_reg[3*CB-1 -: CB]};
    assign dy = {py_reg[CB-1], py_reg} - {cen_reg[2*CB-1], cen_reg[2*CB-1 -: CB]};
    assign dt = {pt_reg[CB-1], pt_reg} - {cen_reg[CB-1], cen_reg[CB-1:0]};

    assign prod_sat = (prod_reg[2*MB-1:64] != '0) ? {64{1'b1}} : prod_reg[63:0];
    assign d2_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign rin  = cmd.rsel ? sqt_reg  : d2_reg;
    assign rrec = cmd.rsel ? trec_reg : srec_reg;

    // Ratio in Q.WEIGHT_FRAC: bits above 2^(64-WF) of the 128-bit product, clamped.
    assign ratio_q = acc_reg[64+63-WF -: 64];
    always_comb
    begin
        if (acc_reg[127:128-WF] != '0)
            ratio_val = ONE_W;
        else if (ratio_q > 64'(ONE_W))
            ratio_val = ONE_W;
        else
            ratio_val = ratio_q[WB-1:0];
    end

    always_comb
    begin
        if (mode_reg)
            s_val = {ONE_W, 1'b0} - {1'b0, ra_reg} - {1'b0, rb_reg};
        else
            s_val = {1'b0, ONE_W} - {1'b0, ra_reg};
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            bbe_pkg::OP_SQX: begin mul_a = MB'(mx_reg); mul_b = MB'(mx_reg); end
            bbe_pkg::OP_SQY: begin mul_a = MB'(my_reg); mul_b = MB'(my_reg); end
            bbe_pkg::OP_SQT: begin mul_a = MB'(mt_reg); mul_b = MB'(mt_reg); end
            bbe_pkg::OP_R0:  begin mul_a = MB'(rin[31:0]);  mul_b = MB'(rrec[31:0]);  end
            bbe_pkg::OP_R1:  begin mul_a = MB'(rin[31:0]);  mul_b = MB'(rrec[63:32]); end
            bbe_pkg::OP_R2:  begin mul_a = MB'(rin[63:32]); mul_b = MB'(rrec[31:0]);  end
            bbe_pkg::OP_R3:  begin mul_a = MB'(rin[63:32]); mul_b = MB'(rrec[63:32]); end
            bbe_pkg::OP_WS:  begin mul_a = MB'(s_val); mul_b = MB'(s_val); end
            default: ;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign push = ((cmd.op == bbe_pkg::OP_EMIT) && pend_valid_reg) ||
                  (cmd.op == bbe_pkg::OP_FIN);

    assign status.mode       = mode_reg;
    assign status.count      = count_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.hit_ok     = mode_reg ?
        ((d2_reg < 64'(srsq_reg)) && (sqt_reg < 64'(trsq_reg))) :
        (d2_reg <= 64'(srsq_reg));

    // Center table.
    always_ff @(posedge clk)
    begin
        if ((cmd.op == bbe_pkg::OP_ACCEPT) && !req_type && (32'(center_slot) < CENTERS))
            mem[IW'(center_slot)] <= {coord_x, coord_y, coord_t};
        if (cmd.op == bbe_pkg::OP_READ)
            cen_reg <= mem[idx];
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            bbe_pkg::OP_ACCEPT:
            begin
                px_reg  <= coord_x;
                py_reg  <= coord_y;
                pt_reg  <= coord_t;
                row_reg <= point_row;
            end
            bbe_pkg::OP_DIFF:
            begin
                mx_reg <= mag(dx);
                my_reg <= mag(dy);
                mt_reg <= mag(dt);
            end
            bbe_pkg::OP_SQY: sqx_reg <= prod_sat;
            bbe_pkg::OP_SQT: sqy_reg <= prod_sat;
            bbe_pkg::OP_D2:
            begin
                sqt_reg <= prod_sat;
                d2_reg  <= d2_sum[64] ? {64{1'b1}} : d2_sum[63:0];
            end
            bbe_pkg::OP_R1: acc_reg <= 128'(prod_reg);
            bbe_pkg::OP_R2: acc_reg <= acc_reg + (128'(prod_reg) << 32);
            bbe_pkg::OP_R3: acc_reg <= acc_reg + (128'(prod_reg) << 32);
            bbe_pkg::OP_R4: acc_reg <= acc_reg + (128'(prod_reg) << 64);
            bbe_pkg::OP_R5:
            begin
                if (cmd.rsel)
                    rb_reg <= ratio_val;
                else
                    ra_reg <= ratio_val;
            end
            bbe_pkg::OP_WF:
                w_reg <= mode_reg ? prod_reg[WF+2 +: WB] : prod_reg[WF +: WB];
            default: ;
        endcase
        if (cmd.op == bbe_pkg::OP_EMIT)
        begin
            pend_col_reg <= bbe_pkg::COL_BITS'(idx);
            pend_w_reg   <= w_reg;
        end
        if (push)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= pend_valid_reg ? pend_col_reg : '0;
            out_w_reg    <= pend_valid_reg ? pend_w_reg : '0;
            out_hit_reg  <= pend_valid_reg;
            out_last_reg <= (cmd.op == bbe_pkg::OP_FIN);
        end
    end

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            srsq_reg       <= '0;
            srec_reg       <= '0;
            trsq_reg       <= '0;
            trec_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bbe_pkg::REG_MODE:      mode_reg  <= cfg_data[0];
                    bbe_pkg::REG_COUNT:     count_reg <= cfg_data[6:0];
                    bbe_pkg::REG_SPACE_RSQ: srsq_reg  <= cfg_data[48:0];
                    bbe_pkg::REG_SPACE_REC: srec_reg  <= cfg_data;
                    bbe_pkg::REG_TIME_RSQ:  trsq_reg  <= cfg_data[48:0];
                    bbe_pkg::REG_TIME_REC:  trec_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == bbe_pkg::OP_EMIT)
                pend_valid_reg <= 1'b1;
            else if (cmd.op == bbe_pkg::OP_FIN)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = out_row_reg;
    assign center_col = out_col_reg;
    assign weight     = out_w_reg;
    assign hit        = out_hit_reg;
    assign last       = out_last_reg;

    // A word is never pushed over one that is still waiting.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free) else $error("output word overwritten");

    // Closing a point always leaves a final word in the output register.
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bbe_pkg::OP_FIN) |=> (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("point closed without final word");

    // An empty marker is always the final word of its point.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> out_last_reg) else $error("marker not last");

    // An emit always leaves a hit stored for output.
    a_emit_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bbe_pkg::OP_EMIT) |=> pend_valid_reg) else $error("hit lost");

endmodule

FILE: hdl/bisquare_basis_evaluator.sv
// Top level of the bisquare basis evaluator: controller plus datapath.
//
//  Channel   Direction  Handshake            Word
//  in        input      in_valid/in_ready    req_type, center_slot, point_row, coords
//  out       output     out_valid/out_ready  row_index, center_col, weight, hit, last
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// A load word writes one table entry and leaves the block ready for the next
// word. A point word is compared with each center in turn and no new word is
// taken until it closes; one shared 33x33 multiplier forms the squares, the
// four partial products of each reciprocal ratio and the weight.
// Reset is asynchronous and active low; it clears configuration and control
// state, while the center table holds nothing defined until loaded.
// The last result of a point sits in the output register while the next word is
// accepted. A stalled output holds the sequencer at an emit while an earlier hit
// still waits to move out, and at the close of a point while the output register
// is full.
module bisquare_basis_evaluator #(
    parameter int CENTERS = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bbe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [bbe_pkg::SLOT_BITS-1:0]       center_slot,
    input  logic [bbe_pkg::ROW_BITS-1:0]        point_row,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    input  logic signed [COORD_BITS-1:0]        coord_t,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bbe_pkg::ROW_BITS-1:0]        row_index,
    output logic [bbe_pkg::COL_BITS-1:0]        center_col,
    output logic [bbe_pkg::WEIGHT_BITS-1:0]     weight,
    output logic                                hit,
    output logic                                last
);

    // Table index width and a center counter wide enough to hold the depth.
    localparam int IW = (CENTERS > 1) ? $clog2(CENTERS) : 1;
    localparam int JW = $clog2(CENTERS + 1);

    bbe_pkg::dp_cmd_t    cmd;
    bbe_pkg::dp_status_t status;
    logic [IW-1:0]       idx;

    // The controller steps in order through the table up to the configured count of centers.
    bbe_ctrl #(
        .CENTERS (CENTERS),
        .IW      (IW),
        .JW      (JW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .idx      (idx)
    );

    // The datapath holds the table, the arithmetic and the output staging.
    bbe_datapath #(
        .CENTERS    (CENTERS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .center_slot (center_slot),
        .point_row   (point_row),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_t     (coord_t),
        .cmd         (cmd),
        .idx         (idx),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_index   (row_index),
        .center_col  (center_col),
        .weight      (weight),
        .hit         (hit),
        .last        (last)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the bisquare basis evaluator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCENT = 64;
    localparam int CB = 24;
    localparam longint unsigned ONE_W = 64'd1 << bbe_pkg::WEIGHT_FRAC;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    typedef enum logic { REQ_LOAD = 1'b0, REQ_POINT = 1'b1 } req_e;
    typedef enum logic { MODE_SPACE = 1'b0, MODE_SPACETIME = 1'b1 } mode_e;

    typedef struct packed {
        logic [bbe_pkg::ROW_BITS-1:0]    row;
        logic [bbe_pkg::COL_BITS-1:0]    col;
        logic [bbe_pkg::WEIGHT_BITS-1:0] w;
        logic                            hit;
        logic                            last;
    } entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bbe_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [bbe_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = 1'b0;
    logic [bbe_pkg::SLOT_BITS-1:0] center_slot = '0;
    logic [bbe_pkg::ROW_BITS-1:0] point_row = '0;
    logic signed [CB-1:0] coord_x = '0;
    logic signed [CB-1:0] coord_y = '0;
    logic signed [CB-1:0] coord_t = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [bbe_pkg::ROW_BITS-1:0] row_index;
    logic [bbe_pkg::COL_BITS-1:0] center_col;
    logic [bbe_pkg::WEIGHT_BITS-1:0] weight;
    logic hit;
    logic last;

    bisquare_basis_evaluator u_top (.*);

    always #10 clk = ~clk;

    // Shadow of the block state used by the weight predictor.
    logic [CB-1:0] cx_tab [NCENT];
    logic [CB-1:0] cy_tab [NCENT];
    logic [CB-1:0] ct_tab [NCENT];
    bit loaded [NCENT];
    mode_e m_mode;
    logic [6:0] m_count;
    longint unsigned m_srsq, m_srec, m_trsq, m_trec;

    entry_t expected_entries[$];
    int errors = 0;
    int send_idle = 0;     // percent of cycles the sender idles
    int recv_idle = 0;     // percent of cycles the receiver stalls
    int hold_off = 0;      // cycles of a forced output stall still to run
    longint cycles = 0;

    // Appends one expected word at the tail of the queue.
    function automatic void queue_expected(entry_t e);
        expected_entries = {expected_entries, e};
    endfunction

    // Squared difference of two signed coordinates, saturating above 64 bits.
    function automatic longint unsigned sq_diff(logic [CB-1:0] a, logic [CB-1:0] b);
        longint d;
        longint unsigned mag;
        d = longint'($signed(a)) - longint'($signed(b));
        mag = (d < 0) ? longint'(-d) : d;
        if (mag > 64'hFFFF_FFFF)
            return '1;
        return mag * mag;
    endfunction

    // d2 * recip scaled to Q.WEIGHT_FRAC and clamped to one.
    function automatic longint unsigned scaled_ratio(longint unsigned d2,
                                                      longint unsigned recip);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, d2} * {64'd0, recip};
        q = p >> (64 - bbe_pkg::WEIGHT_FRAC);
        return (q > ONE_W) ? ONE_W : q[63:0];
    endfunction

    // Expected results of one point against the shadow table.
    task automatic predict_point(logic [bbe_pkg::ROW_BITS-1:0] row, logic [CB-1:0] x,
                                 logic [CB-1:0] y, logic [CB-1:0] t);
        int n;
        int k;
        longint unsigned d2, sx, sy, dt2, om, s, w;
        entry_t e;
        n = (m_count > NCENT) ? NCENT : m_count;
        k = 0;
        for (int j = 0; j < n; j++) begin
            sx = sq_diff(x, cx_tab[j]);
            sy = sq_diff(y, cy_tab[j]);
            d2 = sx + sy;
            if (d2 < sx)
                d2 = '1;
            if (m_mode == MODE_SPACE) begin
                if (d2 > m_srsq)
                    continue;
                om = ONE_W - scaled_ratio(d2, m_srec);
                w = (om * om) >> bbe_pkg::WEIGHT_FRAC;
            end
            else begin
                dt2 = sq_diff(t, ct_tab[j]);
                if (!(d2 < m_srsq && dt2 < m_trsq))
                    continue;
                s = 2 * ONE_W - scaled_ratio(d2, m_srec) - scaled_ratio(dt2, m_trec);
                w = (s * s) >> (bbe_pkg::WEIGHT_FRAC + 2);
            end
            e.row = row; e.col = j[bbe_pkg::COL_BITS-1:0];
            e.w = w[bbe_pkg::WEIGHT_BITS-1:0];
            e.hit = 1'b1; e.last = 1'b0;
            queue_expected(e);
            k++;
        end
        if (k == 0) begin
            e.row = row; e.col = '0; e.w = '0; e.hit = 1'b0; e.last = 1'b1;
            queue_expected(e);
        end
        else
            expected_entries[$].last = 1'b1;
    endtask

    // Sends one word and updates the shadow state on acceptance. Valid stays
    // high after acceptance until the next word replaces it or an idle cycle
    // or a drain drops it at the following falling edge.
    task automatic send_word(req_e kind, logic [bbe_pkg::SLOT_BITS-1:0] slot,
                             logic [bbe_pkg::ROW_BITS-1:0] row, logic [CB-1:0] x,
                             logic [CB-1:0] y, logic [CB-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        center_slot <= slot;
        point_row <= row;
        coord_x <= x;
        coord_y <= y;
        coord_t <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (kind == REQ_LOAD) begin
            cx_tab[slot] = x; cy_tab[slot] = y; ct_tab[slot] = t;
            loaded[slot] = 1'b1;
        end
        else
            predict_point(row, x, y, t);
    endtask

    // Writes one register while the block is idle.
    task automatic write_reg(logic [bbe_pkg::CFG_IDX_BITS-1:0] idx, longint unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bbe_pkg::REG_MODE:      m_mode = mode_e'(val[0]);
            bbe_pkg::REG_COUNT:     m_count = val[6:0];
            bbe_pkg::REG_SPACE_RSQ: m_srsq = val & 64'h1_FFFF_FFFF_FFFF;
            bbe_pkg::REG_SPACE_REC: m_srec = val;
            bbe_pkg::REG_TIME_RSQ:  m_trsq = val & 64'h1_FFFF_FFFF_FFFF;
            bbe_pkg::REG_TIME_REC:  m_trec = val;
            default: ;
        endcase
    endtask

    function automatic longint unsigned recip_of(longint unsigned r);
        logic [64:0] q;
        if (r <= 1)
            return '1;
        q = (65'd1 << 64) / r;
        return q[63:0];
    endfunction

    // Radius registers with a matching reciprocal, saturated for zero.
    task automatic set_radii(longint unsigned srsq, longint unsigned trsq);
        write_reg(bbe_pkg::REG_SPACE_RSQ, srsq);
        write_reg(bbe_pkg::REG_SPACE_REC, recip_of(srsq));
        write_reg(bbe_pkg::REG_TIME_RSQ, trsq);
        write_reg(bbe_pkg::REG_TIME_REC, recip_of(trsq));
    endtask

    // Drops valid, waits until every expected result is in, then idles a while.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Points are drawn near loaded centers so that hits are common.
    task automatic random_point(int spread);
        int j;
        logic [CB-1:0] x, y, t;
        j = $urandom_range(NCENT - 1);
        while (!loaded[j])
            j = $urandom_range(NCENT - 1);
        if ($urandom_range(9) == 0) begin
            x = CB'($urandom); y = CB'($urandom); t = CB'($urandom);
        end
        else begin
            x = cx_tab[j] + CB'($signed($urandom_range(2 * spread) - spread));
            y = cy_tab[j] + CB'($signed($urandom_range(2 * spread) - spread));
            t = ct_tab[j] + CB'($signed($urandom_range(2 * spread) - spread));
        end
        send_word(REQ_POINT, '0, bbe_pkg::ROW_BITS'($urandom), x, y, t);
    endtask

    task automatic load_all_random(int span);
        for (int s = 0; s < NCENT; s++)
            send_word(REQ_LOAD, bbe_pkg::SLOT_BITS'(s), bbe_pkg::ROW_BITS'($urandom),
                      CB'($signed($urandom_range(2 * span) - span)),
                      CB'($signed($urandom_range(2 * span) - span)),
                      CB'($signed($urandom_range(2 * span) - span)));
    endtask

    // Directed: extremes of coordinates, zero count, zero radius, clamping.
    task automatic test_directed();
        logic [CB-1:0] maxc, minc;
        maxc = {1'b0, {(CB-1){1'b1}}};
        minc = {1'b1, {(CB-1){1'b0}}};
        send_word(REQ_LOAD, 6'd0, '0, '0, '0, '0);
        send_word(REQ_LOAD, 6'd1, '1, maxc, minc, maxc);
        send_word(REQ_LOAD, 6'd2, '0, minc, maxc, minc);
        send_word(REQ_LOAD, 6'd63, '0, 24'h000100, 24'hFFFF00, 24'h000010);
        drain();
        // Zero count gives only the empty marker.
        send_word(REQ_POINT, '0, 24'hFFFFFF, '0, '0, '0);
        drain();
        write_reg(bbe_pkg::REG_COUNT, 3);
        set_radii(0, 0);
        // Zero radius: exact hit weighs one; anything else misses.
        send_word(REQ_POINT, '0, 24'd1, '0, '0, '0);
        send_word(REQ_POINT, '0, 24'd2, maxc, minc, '0);
        send_word(REQ_POINT, '0, 24'd3, minc, maxc, maxc);
        drain();
        write_reg(bbe_pkg::REG_MODE, MODE_SPACETIME);
        send_word(REQ_POINT, '0, 24'd4, '0, '0, '0);
        drain();
        // Huge radii with a bogus reciprocal so the ratio clamps.
        write_reg(bbe_pkg::REG_COUNT, 127);
        write_reg(bbe_pkg::REG_SPACE_RSQ, 64'h1_FFFF_FFFF_FFFF);
        write_reg(bbe_pkg::REG_SPACE_REC, '1);
        write_reg(bbe_pkg::REG_TIME_RSQ, 64'h1_FFFF_FFFF_FFFF);
        write_reg(bbe_pkg::REG_TIME_REC, 64'd12345);
        for (int s = 3; s < 63; s++)
            send_word(REQ_LOAD, bbe_pkg::SLOT_BITS'(s), '0, CB'(s << 10),
                      CB'(-(s << 9)), CB'(s << 8));
        drain();
        send_word(REQ_POINT, '0, 24'd5, maxc, maxc, maxc);
        send_word(REQ_POINT, '0, 24'd6, minc, minc, minc);
        send_word(REQ_POINT, '0, 24'd7, 24'h001000, 24'hFFF000, '0);
        drain();
        write_reg(bbe_pkg::REG_MODE, MODE_SPACE);
        send_word(REQ_POINT, '0, 24'd8, maxc, minc, '0);
        send_word(REQ_POINT, '0, 24'd9, 24'h000100, 24'hFFFF00, '0);
        drain();
    endtask

    // Random points near centers across both modes and several radii.
    task automatic test_random(int points, bit reload);
        longint unsigned r;
        if (reload) begin
            load_all_random(1 << 14);
            drain();
        end
        for (int i = 0; i < points; i++) begin
            if (i % 20 == 0) begin
                drain();
                write_reg(bbe_pkg::REG_MODE, $urandom_range(1));
                write_reg(bbe_pkg::REG_COUNT,
                          $urandom_range(3) == 0 ? 64 : $urandom_range(1, 12));
                r = 64'd1 << $urandom_range(20, 34);
                set_radii(r + $urandom_range(1000), r + $urandom_range(1000));
            end
            if ($urandom_range(7) == 0)
                send_word(REQ_LOAD, bbe_pkg::SLOT_BITS'($urandom), '0,
                          CB'($urandom_range(1 << 15)), CB'($urandom_range(1 << 15)),
                          CB'($urandom_range(1 << 15)));
            else
                random_point(1 << 13);
        end
        drain();
    endtask

    // Long output stall with points queued, so the input side backs up.
    task automatic test_backpressure();
        write_reg(bbe_pkg::REG_COUNT, 8);
        write_reg(bbe_pkg::REG_MODE, MODE_SPACE);
        set_radii(64'd1 << 36, 64'd1 << 36);
        hold_off = 400;
        for (int i = 0; i < 10; i++)
            random_point(1 << 10);
        drain();
    endtask

    // Result checker: compares each accepted word with the oldest expectation.
    always @(posedge clk) begin
        entry_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected result row=%h col=%0d w=%h hit=%b last=%b",
                         $realtime, row_index, center_col, weight, hit, last);
                errors++;
            end
            else begin
                e = expected_entries.pop_front();
                if ({row_index, center_col, weight, hit, last} != e) begin
                    $display("%0t: mismatch expected row=%h col=%0d w=%h hit=%b last=%b",
                             $realtime, e.row, e.col, e.w, e.hit, e.last);
                    $display("%0t:          actual   row=%h col=%0d w=%h hit=%b last=%b",
                             $realtime, row_index, center_col, weight, hit, last);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls plus the long forced hold-off.
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NCENT; s++) begin
            cx_tab[s] = '0; cy_tab[s] = '0; ct_tab[s] = '0; loaded[s] = 1'b0;
        end
        m_mode = MODE_SPACE; m_count = '0;
        m_srsq = 0; m_srec = 0; m_trsq = 0; m_trec = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_idle = 24; recv_idle = 75;
        test_directed();
        test_random(50, 1'b1);
        recv_idle = 24; send_idle = 75;
        test_random(50, 1'b0);
        send_idle = 0; recv_idle = 0;
        test_backpressure();
        test_random(30, 1'b0);
        drain();
        if (errors == 0 && expected_entries.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
